@@ rtl/cts_pkg.sv @@
package cts_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS     = 16;

   localparam int CSR_ADDR_BITS = 4;
   localparam logic [1:0] CSR_BASE_INCREMENT     = 2'd0;
   localparam logic [1:0] CSR_SPACING_INCREMENT  = 2'd1;
   localparam logic [1:0] CSR_SAMPLES_PER_SYMBOL = 2'd2;

   localparam logic [31:0] BASE_INCREMENT_RESET     = 32'd357913941;
   localparam logic [31:0] SPACING_INCREMENT_RESET  = 32'd2236962;
   localparam logic [15:0] SAMPLES_PER_SYMBOL_RESET = 16'd1920;

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] AMPLITUDE   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

   typedef struct packed {
      logic [7:0] tone;
      logic       start_message;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          symbol_end;
   } rsp_type;

   typedef struct packed {
      logic [31:0] base_increment;
      logic [31:0] spacing_increment;
      logic [15:0] samples_per_symbol;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic symbol_end;
   } stage_type;

   // (a * b + addend) >> 62, kept to 64 bits
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] addend);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b} + {64'd0, addend};
      return p[125:62];
   endfunction

   // Taylor series, Q62, truncating at every step
   function automatic logic [63:0] sine_q62(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = mul_q62(x, x, 64'd0);
      term = x;
      sum  = x;
      for (int n = 1; n < 20; n++) begin
         term = mul_q62(term, x2, 64'd0) / 64'((2 * n) * (2 * n + 1));
         if ((n & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // quarter-wave entry k of a table with 2^(addr_bits-2) steps
   function automatic logic [SAMPLE_BITS-2:0] sine_entry(input int k, input int addr_bits);
      logic [63:0] step_hi;
      logic [63:0] frac;
      logic [63:0] x;
      logic [63:0] v;
      step_hi = HALF_PI_Q62 >> (addr_bits - 2);
      frac    = HALF_PI_Q62 & ((64'd1 << (addr_bits - 2)) - 64'd1);
      x       = step_hi * 64'(k) + ((frac * 64'(k)) >> (addr_bits - 2));
      v       = mul_q62(sine_q62(x), AMPLITUDE, 64'd1 << 61);
      if (v > AMPLITUDE) begin
         v = AMPLITUDE;
      end
      return v[SAMPLE_BITS-2:0];
   endfunction

endpackage

@@ rtl/cts_csr.sv @@
module cts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cts_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output cts_pkg::cfg_type                    cfg
);

   logic [31:0] base_ff;
   logic [31:0] spacing_ff;
   logic [15:0] sps_ff;
   logic        wr_en;
   logic [1:0]  reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= cts_pkg::BASE_INCREMENT_RESET;
         spacing_ff <= cts_pkg::SPACING_INCREMENT_RESET;
         sps_ff     <= cts_pkg::SAMPLES_PER_SYMBOL_RESET;
      end else if (wr_en) begin
         unique case (reg_index)
            cts_pkg::CSR_BASE_INCREMENT:     base_ff    <= pwdata;
            cts_pkg::CSR_SPACING_INCREMENT:  spacing_ff <= pwdata;
            cts_pkg::CSR_SAMPLES_PER_SYMBOL: sps_ff     <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         cts_pkg::CSR_BASE_INCREMENT:     prdata = base_ff;
         cts_pkg::CSR_SPACING_INCREMENT:  prdata = spacing_ff;
         cts_pkg::CSR_SAMPLES_PER_SYMBOL: prdata = {16'd0, sps_ff};
         default:                         prdata = 32'd0;
      endcase
   end

   assign cfg.base_increment     = base_ff;
   assign cfg.spacing_increment  = spacing_ff;
   assign cfg.samples_per_symbol = sps_ff;

endmodule

@@ rtl/cts_phase.sv @@
module cts_phase #(
   parameter int PHASE_BITS = cts_pkg::PHASE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cts_pkg::req_type        req_payload,
   input  cts_pkg::cfg_type        cfg,
   input  logic                    down_ready,
   output cts_pkg::stage_type      down_ctrl,
   output logic [PHASE_BITS-1:0]   down_phase
);

   localparam int STEP_BITS = 40;
   localparam int WIDE_BITS = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;

   // stage 1: phase step
   logic                  s1_valid_ff, s1_valid_in;
   logic [PHASE_BITS-1:0] s1_step_ff, s1_step_in;
   logic                  s1_start_ff;
   // stage 2: accumulator and sample counter
   logic                  s2_valid_ff, s2_valid_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [15:0]           cnt_ff, cnt_in;
   logic                  end_ff, end_in;

   logic                  ld1, ld2, s2_load;
   logic [STEP_BITS-1:0]  prod;
   logic [WIDE_BITS-1:0]  step_wide;
   logic [PHASE_BITS-1:0] phase_base;
   logic [15:0]           cnt_base;
   logic [16:0]           cnt_next;

   assign ld2       = !s2_valid_ff || down_ready;
   assign ld1       = !s1_valid_ff || ld2;
   assign req_ready = ld1;
   assign s2_load   = ld2 && s1_valid_ff;

   always_comb begin
      prod        = STEP_BITS'(req_payload.tone) * STEP_BITS'(cfg.spacing_increment);
      step_wide   = WIDE_BITS'(prod + STEP_BITS'(cfg.base_increment));
      s1_step_in  = step_wide[PHASE_BITS-1:0];
      s1_valid_in = ld1 ? req_valid : s1_valid_ff;
   end

   always_comb begin
      phase_base  = s1_start_ff ? '0 : phase_ff;
      cnt_base    = s1_start_ff ? 16'd0 : cnt_ff;
      cnt_next    = {1'b0, cnt_base} + 17'd1;
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      end_in      = end_ff;
      s2_valid_in = ld2 ? s1_valid_ff : s2_valid_ff;
      if (s2_load) begin
         phase_in = phase_base + s1_step_ff;
         if (cnt_next >= {1'b0, cfg.samples_per_symbol}) begin
            end_in = 1'b1;
            cnt_in = 16'd0;
         end else begin
            end_in = 1'b0;
            cnt_in = cnt_next[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         phase_ff    <= '0;
         cnt_ff      <= 16'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_step_ff  <= s1_step_in;
         s1_start_ff <= req_payload.start_message;
      end
      end_ff <= end_in;
   end

   assign down_ctrl.valid      = s2_valid_ff;
   assign down_ctrl.symbol_end = end_ff;
   assign down_phase           = phase_ff;

   a_start_restarts_phase: assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_start_ff) |=> (phase_ff == $past(s1_step_ff)))
      else $error("phase not restarted on start of message");

   a_end_clears_count: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> (end_ff == (cnt_ff == 16'd0)))
      else $error("symbol end and sample counter disagree");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !ld2) |=> (s1_valid_ff && $stable(s1_step_ff)))
      else $error("stage 1 item lost while stalled");

endmodule

@@ rtl/cts_sine.sv @@
module cts_sine #(
   parameter int PHASE_BITS      = cts_pkg::PHASE_BITS,
   parameter int TABLE_ADDR_BITS = cts_pkg::TABLE_ADDR_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cts_pkg::stage_type      up_ctrl,
   input  logic [PHASE_BITS-1:0]   up_phase,
   output logic                    up_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cts_pkg::rsp_type        rsp_payload
);

   localparam int SB       = cts_pkg::SAMPLE_BITS;
   localparam int QUARTER  = 1 << (TABLE_ADDR_BITS - 2);
   localparam int ROM_BITS = TABLE_ADDR_BITS - 1;

   typedef logic [SB-2:0] rom_type [QUARTER+1];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k <= QUARTER; k++) begin
         r[k] = cts_pkg::sine_entry(k, TABLE_ADDR_BITS);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [TABLE_ADDR_BITS-1:0] addr;
   logic [ROM_BITS-1:0]        idx, rom_addr;
   logic                       ld3, ld4;

   logic          s3_valid_ff, s3_valid_in;
   logic [SB-2:0] mag_ff;
   logic          neg_ff, s3_end_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   cts_pkg::rsp_type rsp_ff, rsp_in;

   assign ld4      = !rsp_valid_ff || rsp_ready;
   assign ld3      = !s3_valid_ff || ld4;
   assign up_ready = ld3;

   always_comb begin
      addr     = up_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      idx      = {1'b0, addr[TABLE_ADDR_BITS-3:0]};
      rom_addr = addr[TABLE_ADDR_BITS-2] ? (ROM_BITS'(QUARTER) - idx) : idx;
      s3_valid_in  = ld3 ? up_ctrl.valid : s3_valid_ff;
      rsp_valid_in = ld4 ? s3_valid_ff : rsp_valid_ff;
      rsp_in.sample     = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
      rsp_in.symbol_end = s3_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         mag_ff    <= SINE_ROM[rom_addr];
         neg_ff    <= addr[TABLE_ADDR_BITS-1];
         s3_end_ff <= up_ctrl.symbol_end;
      end
      if (ld4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rom_data_holds: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !ld4) |=> (s3_valid_ff && $stable(mag_ff) && $stable(neg_ff)))
      else $error("table read lost while output stalled");

   a_refill_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && s3_valid_ff) |=> rsp_valid_ff)
      else $error("waiting item not moved to output");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result item changed while stalled");

endmodule

@@ rtl/cpfsk_tone_synthesizer_top.sv @@
// Path: an accepted item moves in order through the stage 1, 2, 3 and output registers.
// Throughput: one item per cycle unless rsp_ready stalls; the phase accumulator
// loops through a single register, and the sine table is a synchronous ROM read once per item.
// Output stalls fill the four stages before req_ready drops.
// Reset: synchronous; clears phase, sample counter and stage valids, and loads
// the register reset values. No clearing pass.
module cpfsk_tone_synthesizer_top #(
   parameter int PHASE_BITS      = cts_pkg::PHASE_BITS,
   parameter int TABLE_ADDR_BITS = cts_pkg::TABLE_ADDR_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cts_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cts_pkg::rsp_type                  rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cts_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   cts_pkg::cfg_type      cfg;
   cts_pkg::stage_type    acc_ctrl;
   logic [PHASE_BITS-1:0] acc_phase;
   logic                  sine_ready;

   cts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cts_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg),
      .down_ready  (sine_ready),
      .down_ctrl   (acc_ctrl),
      .down_phase  (acc_phase)
   );

   cts_sine #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_sine (
      .clock       (clock),
      .reset       (reset),
      .up_ctrl     (acc_ctrl),
      .up_phase    (acc_phase),
      .up_ready    (sine_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
